// ----- rtl/kcu_pkg.sv -----
// shared constants, types and helpers for the combination unranking block
`default_nettype none
package kcu_pkg;

	localparam int MAX_A     = 32;
	localparam int MAX_Z     = 32;
	localparam int TBL_COLS  = MAX_Z + 1;
	localparam int TBL_DEPTH = (MAX_A + 1) * TBL_COLS;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);

	localparam int CNT_W  = 6;
	localparam int RANK_W = 30;
	localparam int VAL_W  = 30;
	localparam int PAT_W  = 64;
	localparam int LEN_W  = 7;

	localparam logic [VAL_W-1:0] SAT_VALUE = VAL_W'(1000000001);

	typedef struct packed {
		logic load;
		logic bld_rd;
		logic bld_wr;
		logic walk_init;
		logic walk_step;
		logic set_nf;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic bld_edge;
		logic bld_last;
		logic nf;
		logic empty;
		logic walk_done;
		logic out_free;
	} sts_t;

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [CNT_W-1:0] i,
		input logic [CNT_W-1:0] j);
		logic [ADDR_W-1:0] r;
		r = ADDR_W'(i) * ADDR_W'(TBL_COLS) + ADDR_W'(j);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/kcu_req_if.sv -----
// request channel: symbol counts and rank
`default_nettype none
interface kcu_req_if;
	import kcu_pkg::*;

	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  count_a;
	logic [CNT_W-1:0]  count_z;
	logic [RANK_W-1:0] rank;

	modport source(output valid, count_a, count_z, rank, input ready);
	modport sink(input valid, count_a, count_z, rank, output ready);
endinterface
`default_nettype wire

// ----- rtl/kcu_rsp_if.sv -----
// response channel: unranked pattern, length and not-found flag
`default_nettype none
interface kcu_rsp_if;
	import kcu_pkg::*;

	logic             valid;
	logic             ready;
	logic [PAT_W-1:0] pattern;
	logic [LEN_W-1:0] length;
	logic             not_found;

	modport source(output valid, pattern, length, not_found, input ready);
	modport sink(input valid, pattern, length, not_found, output ready);
endinterface
`default_nettype wire

// ----- rtl/kcu_ram.sv -----
// generic single-write single-read ram with registered read data
`default_nettype none
module kcu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

// ----- rtl/kcu_dp.sv -----
// datapath: table build, range check, table walk and output register
`default_nettype none
module kcu_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire kcu_pkg::cmd_t                   cmd,
	output kcu_pkg::sts_t                        sts,
	input  wire logic [kcu_pkg::CNT_W-1:0]       count_a,
	input  wire logic [kcu_pkg::CNT_W-1:0]       count_z,
	input  wire logic [kcu_pkg::RANK_W-1:0]      rank,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [kcu_pkg::PAT_W-1:0]       out_pattern,
	output logic      [kcu_pkg::LEN_W-1:0]       out_length,
	output logic                                 out_not_found
);
	import kcu_pkg::*;

	logic [CNT_W-1:0]  bi_q, bj_q;
	logic [VAL_W-1:0]  left_q;
	logic [CNT_W-1:0]  a_q, z_q;
	logic [RANK_W-1:0] k_q;
	logic [LEN_W-1:0]  total_q;
	logic [LEN_W-1:0]  pos_q;
	logic [PAT_W-1:0]  pattern_q;
	logic              nf_q;
	logic              sel_q;
	logic              out_valid_q;
	logic [PAT_W-1:0]  out_pattern_q;
	logic [LEN_W-1:0]  out_length_q;
	logic              out_nf_q;

	logic [ADDR_W-1:0] rd0_addr, rd1_addr, wr_addr;
	logic [VAL_W-1:0]  rd0_data, rd1_data, wr_data;
	logic [VAL_W-1:0]  t;
	logic [VAL_W:0]    sum;
	logic              go_a;
	logic              range_bad;
	logic [PAT_W-1:0]  tail;

	// two identical copies so both next-step candidates are read at once
	kcu_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_tbl0 (
		.clk(clk), .wr_en(cmd.bld_wr), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd0_addr), .rd_data(rd0_data)
	);
	kcu_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_tbl1 (
		.clk(clk), .wr_en(cmd.bld_wr), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd1_addr), .rd_data(rd1_data)
	);

	always_comb begin
		t         = sel_q ? rd1_data : rd0_data;
		go_a      = (k_q <= t);
		range_bad = (a_q > CNT_W'(MAX_A)) || (z_q > CNT_W'(MAX_Z)) ||
			(total_q > LEN_W'(PAT_W));
		sum       = {1'b0, rd0_data} + {1'b0, left_q};
		wr_addr   = tbl_addr(bi_q, bj_q);
		if (sts.bld_edge) begin
			wr_data = VAL_W'(1);
		end else if (sum > {1'b0, SAT_VALUE}) begin
			wr_data = SAT_VALUE;
		end else begin
			wr_data = sum[VAL_W-1:0];
		end
		// ones from the current position up to the end of the string
		tail = ({PAT_W{1'b1}} << pos_q) & ~({PAT_W{1'b1}} << total_q);
	end

	always_comb begin
		rd0_addr = '0;
		if (cmd.load) begin
			if ((count_a <= CNT_W'(MAX_A)) && (count_z <= CNT_W'(MAX_Z))) begin
				rd0_addr = tbl_addr(count_a, count_z);
			end
		end else if (cmd.bld_rd) begin
			rd0_addr = tbl_addr(bi_q - CNT_W'(1), bj_q);
		end else if (cmd.walk_init) begin
			rd0_addr = tbl_addr(a_q - CNT_W'(1), z_q);
		end else if (cmd.walk_step && (a_q >= CNT_W'(2))) begin
			rd0_addr = tbl_addr(a_q - CNT_W'(2), z_q);
		end
		rd1_addr = '0;
		if (cmd.walk_step && (a_q != '0) && (z_q != '0)) begin
			rd1_addr = tbl_addr(a_q - CNT_W'(1), z_q - CNT_W'(1));
		end
	end

	always_comb begin
		sts.bld_edge  = (bi_q == '0) || (bj_q == '0);
		sts.bld_last  = (bi_q == CNT_W'(MAX_A)) && (bj_q == CNT_W'(MAX_Z));
		sts.nf        = range_bad || (k_q > rd0_data);
		sts.empty     = (a_q == '0) || (z_q == '0);
		sts.walk_done = go_a ? (a_q == CNT_W'(1)) : (z_q == CNT_W'(1));
		sts.out_free  = !out_valid_q || out_ready;
	end

	// build counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bi_q <= '0;
			bj_q <= '0;
		end else if (cmd.bld_wr) begin
			if (bj_q == CNT_W'(MAX_Z)) begin
				bj_q <= '0;
				bi_q <= bi_q + CNT_W'(1);
			end else begin
				bj_q <= bj_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bld_wr) begin
			left_q <= wr_data;
		end
		if (cmd.load) begin
			a_q       <= count_a;
			z_q       <= count_z;
			k_q       <= rank;
			total_q   <= LEN_W'(count_a) + LEN_W'(count_z);
			pos_q     <= '0;
			pattern_q <= '0;
			nf_q      <= 1'b0;
		end
		if (cmd.set_nf) begin
			nf_q <= 1'b1;
		end
		if (cmd.walk_init) begin
			sel_q <= 1'b0;
		end
		if (cmd.walk_step) begin
			sel_q <= !go_a;
			pos_q <= pos_q + LEN_W'(1);
			if (go_a) begin
				a_q <= a_q - CNT_W'(1);
			end else begin
				z_q <= z_q - CNT_W'(1);
				k_q <= k_q - t;
				pattern_q[pos_q[5:0]] <= 1'b1;
			end
		end
	end

	// output register, decoupled from the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_nf_q <= nf_q;
			if (nf_q) begin
				out_pattern_q <= '0;
				out_length_q  <= '0;
			end else begin
				out_pattern_q <= (z_q != '0) ? (pattern_q | tail) : pattern_q;
				out_length_q  <= total_q;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_pattern   = out_pattern_q;
	assign out_length    = out_length_q;
	assign out_not_found = out_nf_q;
endmodule
`default_nettype wire

// ----- rtl/kcu_ctrl.sv -----
// controller: table build sequencing and per-item walk state machine
`default_nettype none
module kcu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire kcu_pkg::sts_t sts,
	output kcu_pkg::cmd_t      cmd
);
	import kcu_pkg::*;

	localparam logic [2:0] ST_BUILD  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_WALK   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q, state_d;
	logic       phase_q, phase_d;

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_BUILD: begin
				// inner entries take a read of the row above, then the write
				if (phase_q) begin
					cmd.bld_wr = 1'b1;
					phase_d    = 1'b0;
				end else if (sts.bld_edge) begin
					cmd.bld_wr = 1'b1;
				end else begin
					cmd.bld_rd = 1'b1;
					phase_d    = 1'b1;
				end
				if (cmd.bld_wr && sts.bld_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.nf) begin
					cmd.set_nf = 1'b1;
					state_d    = ST_FINISH;
				end else if (sts.empty) begin
					state_d = ST_FINISH;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_BUILD;
				phase_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BUILD;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/kth_combination_unrank.sv -----
// an item passes from accept through the check state, s walk steps and the finish state,
// which waits for a free output register; s <= count_a + count_z - 1 is the number of table
// walk steps, one per emitted symbol until one count runs out, one step per cycle
// from two mirrored copies; a new item is accepted only after the last one is emitted
// reset: a table build runs first; no beat is accepted until it ends
`default_nettype none
module kth_combination_unrank (
	input wire logic  clk,
	input wire logic  arst_n,
	kcu_req_if.sink   req,
	kcu_rsp_if.source rsp
);
	import kcu_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	kcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kcu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.count_a       (req.count_a),
		.count_z       (req.count_z),
		.rank          (req.rank),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_pattern   (rsp.pattern),
		.out_length    (rsp.length),
		.out_not_found (rsp.not_found)
	);

	assign req.ready = in_ready;
endmodule
`default_nettype wire

// ----- tb/sv/kcu_unrank_checker.sv -----
// checker: predicts each unranked arrangement and compares it with the response channel
`default_nettype none
module kcu_unrank_checker (
	input wire logic clk,
	input wire logic arst_n,
	kcu_req_if       req,
	kcu_rsp_if       rsp,
	output int       fails,
	output int       pending
);
	import kcu_pkg::*;

	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] length;
		logic             not_found;
	} unrank_t;

	logic [VAL_W-1:0] path_count [0:MAX_A][0:MAX_Z];
	unrank_t          unranked_q [$];
	int               err_cnt = 0;
	int               q_len   = 0;

	assign fails   = err_cnt;
	assign pending = q_len;

	// saturated pascal table, same contents the block builds after reset
	initial begin : build_counts
		int unsigned s;
		for (int i = 0; i <= MAX_A; i++) begin
			for (int j = 0; j <= MAX_Z; j++) begin
				if (i == 0 || j == 0) begin
					path_count[i][j] = VAL_W'(1);
				end else begin
					s = int'(path_count[i-1][j]) + int'(path_count[i][j-1]);
					path_count[i][j] = (s > SAT_VALUE) ? SAT_VALUE : VAL_W'(s);
				end
			end
		end
	end

	function automatic unrank_t unrank(input logic [CNT_W-1:0] ca, input logic [CNT_W-1:0] cz,
		input logic [RANK_W-1:0] rk);
		int unsigned a, z, k, pos, total;
		unrank_t     r;
		a     = ca;
		z     = cz;
		k     = rk;
		total = a + z;
		r     = '0;
		if (a > MAX_A || z > MAX_Z || total > PAT_W) begin
			r.not_found = 1'b1;
			return r;
		end
		if (k > path_count[a][z]) begin
			r.not_found = 1'b1;
			return r;
		end
		pos = 0;
		// rank falls in the block of strings starting with 'a', or past it
		while (a > 0 && z > 0) begin
			if (k <= path_count[a-1][z]) begin
				a--;
			end else begin
				r.pattern[pos] = 1'b1;
				k -= path_count[a-1][z];
				z--;
			end
			pos++;
		end
		pos += a;
		while (z > 0) begin
			r.pattern[pos] = 1'b1;
			pos++;
			z--;
		end
		r.length = LEN_W'(total);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		unrank_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (unranked_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result beat pattern=%h length=%0d not_found=%0b",
						$time, rsp.pattern, rsp.length, rsp.not_found);
				end else begin
					want = unranked_q.pop_front();
					if (rsp.pattern !== want.pattern) begin
						err_cnt++;
						$display("%0t: pattern expected %h got %h",
							$time, want.pattern, rsp.pattern);
					end
					if (rsp.length !== want.length) begin
						err_cnt++;
						$display("%0t: length expected %0d got %0d",
							$time, want.length, rsp.length);
					end
					if (rsp.not_found !== want.not_found) begin
						err_cnt++;
						$display("%0t: not_found expected %0b got %0b",
							$time, want.not_found, rsp.not_found);
					end
				end
			end
			// a new request passes the check and finish states and the output register first, so it never answers this beat
			if (req.valid && req.ready) begin
				unranked_q.push_back(unrank(req.count_a, req.count_z, req.rank));
			end
			q_len <= unranked_q.size();
		end
	end

endmodule
`default_nettype wire

// ----- tb/sv/tb_kth_combination_unrank.sv -----
// testbench top: drives unranking requests, paces responses and reports the verdict
`default_nettype none
module tb_kth_combination_unrank;
	import kcu_pkg::*;

	localparam int N_RANDOM = 1300;
	localparam int N_CALM   = 200;
	localparam int LIMIT    = 500000;
	localparam int DRAIN    = 100;
	localparam int HOLD_OFF = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic calm   = 1'b0;
	int   fail_cnt;
	int   pending;
	int   cycle_cnt = 0;
	int   rsp_cnt   = 0;
	int   nf_cnt    = 0;
	int   sent_cnt  = 0;

	kcu_req_if req ();
	kcu_rsp_if rsp ();

	kth_combination_unrank dut (
		.clk,
		.arst_n,
		.req(req),
		.rsp(rsp)
	);

	kcu_unrank_checker chk (
		.clk,
		.arst_n,
		.req(req),
		.rsp(rsp),
		.fails(fail_cnt),
		.pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (rsp.valid && rsp.ready) begin
			rsp_cnt <= rsp_cnt + 1;
			if (rsp.not_found) begin
				nf_cnt <= nf_cnt + 1;
			end
		end
	end

	// number of arrangements, saturated the way the block's table is
	function automatic longint unsigned arrangements(input int unsigned a, input int unsigned z);
		longint unsigned r;
		int unsigned     n, k;
		n = a + z;
		k = (a < z) ? a : z;
		r = 1;
		for (int unsigned i = 0; i < k; i++) begin
			r = r * (n - i) / (i + 1);
			if (r >= SAT_VALUE) begin
				return SAT_VALUE;
			end
		end
		return r;
	endfunction

	task automatic send_item(input int unsigned a, input int unsigned z,
		input logic [RANK_W-1:0] rk);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid   <= 1'b1;
		req.count_a <= CNT_W'(a);
		req.count_z <= CNT_W'(z);
		req.rank    <= rk;
		do @(posedge clk); while (!req.ready);
		sent_cnt++;
		@(negedge clk);
	endtask

	initial begin : stim
		int unsigned     a, z, sel;
		longint unsigned cnt;
		logic [RANK_W-1:0] rk;
		req.valid   = 1'b0;
		req.count_a = '0;
		req.count_z = '0;
		req.rank    = '0;
		arst_n      = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty set, smallest sets and their edges
		send_item(0, 0, 1);
		send_item(0, 0, 0);
		send_item(0, 0, 2);
		send_item(1, 0, 1);
		send_item(0, 1, 1);
		send_item(1, 1, 2);
		send_item(1, 1, 3);
		send_item(3, 3, 0);
		send_item(5, 5, 252);
		send_item(5, 5, 253);
		send_item(32, 0, 1);
		send_item(0, 32, 1);
		// saturated entry at the largest table corner
		send_item(32, 32, 1);
		send_item(32, 32, 1000000000);
		send_item(32, 32, 1000000001);
		send_item(32, 32, 1000000002);
		send_item(32, 32, '1);
		send_item(16, 16, 601080390);
		send_item(16, 16, 601080391);
		send_item(32, 31, 777);
		// counts outside the table
		send_item(33, 0, 1);
		send_item(0, 33, 1);
		send_item(31, 33, 1);
		send_item(63, 63, '1);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - N_CALM) begin
				calm <= 1'b1;
			end
			if (n == N_RANDOM / 2) begin
				// let the block run dry before going on
				req.valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
			end
			if ($urandom_range(0, 2) == 0) begin
				a = $urandom_range(0, MAX_A);
				z = $urandom_range(0, MAX_Z);
			end else begin
				a = $urandom_range(0, 8);
				z = $urandom_range(0, 8);
			end
			cnt = arrangements(a, z);
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				rk = RANK_W'($urandom_range(1, int'(cnt)));
			end else if (sel < 78) begin
				rk = RANK_W'(cnt + 1);
			end else if (sel < 84) begin
				rk = RANK_W'(cnt);
			end else if (sel < 90) begin
				rk = RANK_W'($urandom);
			end else if (sel < 95) begin
				a  = $urandom_range(0, 63);
				z  = $urandom_range(0, 63);
				rk = RANK_W'($urandom);
			end else begin
				rk = '0;
			end
			send_item(a, z, rk);
		end
		req.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("sent %0d requests, checked %0d results (%0d not found) in %0d cycles",
			sent_cnt, rsp_cnt, nf_cnt, cycle_cnt);
		$display("covered empty, saturated, oversized and rank-zero requests with random stalls");
		if (fail_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// response side: random stalls, one long hold-off, steady ready at the end
	initial begin : sink
		int stall, hold;
		bit held;
		rsp.ready = 1'b0;
		stall     = 0;
		hold      = 0;
		held      = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && rsp_cnt >= 40) begin
				held = 1'b1;
				hold = HOLD_OFF;
			end
			if (hold > 0) begin
				hold--;
				rsp.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 6);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		wait (cycle_cnt >= LIMIT);
		$display("timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
